// ----- hdl/pacf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pacf_pkg
// Shared types and constants of the pileup allele count filter: character
// codes, item classes, threshold register indexes and default sizes.
// ----------------------------------------------------------------------------
package pacf_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int FIFO_DEPTH_DEF  = 4;

  localparam int CFG_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int FIELD_WIDTH   = 16;
  localparam int POS_WIDTH     = 31;
  localparam int CHAR_WIDTH    = 8;
  localparam int BASE_WIDTH    = 2;

  localparam logic [CHAR_WIDTH-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_WIDTH-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UC    = 8'h43;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LC    = 8'h63;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UG    = 8'h47;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LG    = 8'h67;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UT    = 8'h54;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LT    = 8'h74;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_REF_THRESHOLD   = 2'd0,
    REG_ALT_THRESHOLD   = 2'd1,
    REG_TOTAL_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef enum logic [BASE_WIDTH-1:0] {
    BASE_A = 2'd0,
    BASE_C = 2'd1,
    BASE_G = 2'd2,
    BASE_T = 2'd3
  } base_t;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_OTHER,
    CLS_MATCH,
    CLS_A,
    CLS_C,
    CLS_G,
    CLS_T
  } char_class_t;

  typedef struct packed {
    char_class_t            cls;
    logic                   site_end;
    logic [POS_WIDTH-1:0]   position;
    logic [CHAR_WIDTH-1:0]  reference;
  } item_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] ref_min;
    logic [CFG_WIDTH-1:0] alt_min;
    logic [CFG_WIDTH-1:0] total_min;
  } thresh_t;

endpackage
`default_nettype wire

// ----- hdl/pacf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pacf_front
// Input stage: accepts read characters and registers them with their class
// (absent, match, base A/C/G/T or other) for the queue.
// ----------------------------------------------------------------------------
module pacf_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [pacf_pkg::CHAR_WIDTH-1:0]    read_char,
  input  wire logic                               char_present,
  input  wire logic                               site_end,
  input  wire logic [pacf_pkg::POS_WIDTH-1:0]     site_position,
  input  wire logic [pacf_pkg::CHAR_WIDTH-1:0]    reference_base,
  output logic                                    push,
  output pacf_pkg::item_t                         push_item,
  input  wire logic                               full
);

  logic                  hold_valid;
  pacf_pkg::item_t       hold_item;
  pacf_pkg::char_class_t cls;

  always_comb begin
    if (!char_present) begin
      cls = pacf_pkg::CLS_NONE;
    end else begin
      unique case (read_char) inside
        pacf_pkg::CHAR_DOT, pacf_pkg::CHAR_COMMA: cls = pacf_pkg::CLS_MATCH;
        pacf_pkg::CHAR_UA, pacf_pkg::CHAR_LA:     cls = pacf_pkg::CLS_A;
        pacf_pkg::CHAR_UC, pacf_pkg::CHAR_LC:     cls = pacf_pkg::CLS_C;
        pacf_pkg::CHAR_UG, pacf_pkg::CHAR_LG:     cls = pacf_pkg::CLS_G;
        pacf_pkg::CHAR_UT, pacf_pkg::CHAR_LT:     cls = pacf_pkg::CLS_T;
        default:                                  cls = pacf_pkg::CLS_OTHER;
      endcase
    end
  end

  assign push      = hold_valid && !full;
  assign push_item = hold_item;
  assign in_ready  = !hold_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item.cls       <= cls;
      hold_item.site_end  <= site_end;
      hold_item.position  <= site_position;
      hold_item.reference <= reference_base;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pacf_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pacf_fifo
// Short queue of classified items between the front and back stages.
// ----------------------------------------------------------------------------
module pacf_fifo #(
  parameter int DEPTH = pacf_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire pacf_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 pop_valid,
  output pacf_pkg::item_t      pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  pacf_pkg::item_t mem [DEPTH];
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == LAST) ? '0 : tail + PW'(1);
      end
      if (pop) begin
        head <= (head == LAST) ? '0 : head + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pacf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pacf_back
// Back stage: saturating per-site counters, site snapshot, best alternate
// selection, threshold test and output register.
// ----------------------------------------------------------------------------
module pacf_back #(
  parameter int COUNT_WIDTH = pacf_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pacf_pkg::thresh_t                   thresh,
  input  wire logic                                item_valid,
  input  wire pacf_pkg::item_t                     item,
  output logic                                     pop,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [pacf_pkg::POS_WIDTH-1:0]           kept_position,
  output logic [pacf_pkg::CHAR_WIDTH-1:0]          kept_reference,
  output logic [pacf_pkg::FIELD_WIDTH-1:0]         match_count,
  output logic [pacf_pkg::FIELD_WIDTH-1:0]         best_alt_count,
  output logic [pacf_pkg::BASE_WIDTH-1:0]          best_alt_base
);

  localparam int CMPW = ((COUNT_WIDTH > pacf_pkg::CFG_WIDTH) ?
                         COUNT_WIDTH : pacf_pkg::CFG_WIDTH) + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // running counters
  cnt_t char_total;
  cnt_t match_tally;
  cnt_t base_tally [4];
  cnt_t char_total_next;
  cnt_t match_tally_next;
  cnt_t base_tally_next [4];

  // site snapshot
  logic                              s1_valid;
  cnt_t                              s1_total;
  cnt_t                              s1_match;
  cnt_t                              s1_base [4];
  logic [pacf_pkg::POS_WIDTH-1:0]    s1_pos;
  logic [pacf_pkg::CHAR_WIDTH-1:0]   s1_ref;

  // best alternate chosen
  logic                              s2_valid;
  cnt_t                              s2_total;
  cnt_t                              s2_match;
  cnt_t                              s2_best;
  pacf_pkg::base_t                   s2_base;
  logic [pacf_pkg::POS_WIDTH-1:0]    s2_pos;
  logic [pacf_pkg::CHAR_WIDTH-1:0]   s2_ref;

  logic            out_free, s2_go, s2_free, s1_free, keep;
  cnt_t            lo_cnt, hi_cnt, best_cnt;
  pacf_pkg::base_t lo_base, hi_base, best_base;
  logic [CMPW-1:0] e_total, e_match, e_best, e_sum;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [pacf_pkg::FIELD_WIDTH-1:0] clamp16(input cnt_t v);
    logic [CMPW-1:0] e;
    e = CMPW'(v);
    clamp16 = (e > CMPW'(16'hFFFF)) ? 16'hFFFF : e[pacf_pkg::FIELD_WIDTH-1:0];
  endfunction

  // stall chain
  assign out_free = !out_valid || out_ready;
  assign s2_go    = !keep || out_free;
  assign s2_free  = !s2_valid || s2_go;
  assign s1_free  = !s1_valid || s2_free;
  assign pop      = item_valid && (!item.site_end || s1_free);

  always_comb begin
    char_total_next  = char_total;
    match_tally_next = match_tally;
    for (int i = 0; i < 4; i++) begin
      base_tally_next[i] = base_tally[i];
    end
    if (item.cls != pacf_pkg::CLS_NONE) begin
      char_total_next = sat_inc(char_total);
    end
    case (item.cls)
      pacf_pkg::CLS_MATCH: match_tally_next   = sat_inc(match_tally);
      pacf_pkg::CLS_A:     base_tally_next[0] = sat_inc(base_tally[0]);
      pacf_pkg::CLS_C:     base_tally_next[1] = sat_inc(base_tally[1]);
      pacf_pkg::CLS_G:     base_tally_next[2] = sat_inc(base_tally[2]);
      pacf_pkg::CLS_T:     base_tally_next[3] = sat_inc(base_tally[3]);
      default:             ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_total  <= '0;
      match_tally <= '0;
      for (int i = 0; i < 4; i++) begin
        base_tally[i] <= '0;
      end
    end else if (pop) begin
      if (item.site_end) begin
        char_total  <= '0;
        match_tally <= '0;
        for (int i = 0; i < 4; i++) begin
          base_tally[i] <= '0;
        end
      end else begin
        char_total  <= char_total_next;
        match_tally <= match_tally_next;
        for (int i = 0; i < 4; i++) begin
          base_tally[i] <= base_tally_next[i];
        end
      end
    end
  end

  // snapshot at site end
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pop && item.site_end;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && pop && item.site_end) begin
      s1_total <= char_total_next;
      s1_match <= match_tally_next;
      for (int i = 0; i < 4; i++) begin
        s1_base[i] <= base_tally_next[i];
      end
      s1_pos <= item.position;
      s1_ref <= item.reference;
    end
  end

  // best alternate, earlier base wins ties
  always_comb begin
    if (s1_base[1] > s1_base[0]) begin
      lo_cnt  = s1_base[1];
      lo_base = pacf_pkg::BASE_C;
    end else begin
      lo_cnt  = s1_base[0];
      lo_base = pacf_pkg::BASE_A;
    end
    if (s1_base[3] > s1_base[2]) begin
      hi_cnt  = s1_base[3];
      hi_base = pacf_pkg::BASE_T;
    end else begin
      hi_cnt  = s1_base[2];
      hi_base = pacf_pkg::BASE_G;
    end
    if (hi_cnt > lo_cnt) begin
      best_cnt  = hi_cnt;
      best_base = hi_base;
    end else begin
      best_cnt  = lo_cnt;
      best_base = lo_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_total <= s1_total;
      s2_match <= s1_match;
      s2_best  <= best_cnt;
      s2_base  <= best_base;
      s2_pos   <= s1_pos;
      s2_ref   <= s1_ref;
    end
  end

  // threshold test
  assign e_total = CMPW'(s2_total);
  assign e_match = CMPW'(s2_match);
  assign e_best  = CMPW'(s2_best);
  assign e_sum   = e_match + e_best;
  assign keep    = (e_total >= CMPW'(thresh.total_min))
                && (e_match >= CMPW'(thresh.ref_min))
                && (e_best  >= CMPW'(thresh.alt_min))
                && (e_sum   >= CMPW'(thresh.total_min));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid && keep) begin
      kept_position  <= s2_pos;
      kept_reference <= s2_ref;
      match_count    <= clamp16(s2_match);
      best_alt_count <= clamp16(s2_best);
      best_alt_base  <= s2_base;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pileup_allele_count_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pileup_allele_count_filter
// Counts read-base characters of a pileup site and emits the site with its
// reference and best alternate counts when all thresholds pass.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    read_char, char_present, site_end,
//                                   site_position, reference_base
//  output    out_valid / out_ready  kept_position, kept_reference,
//                                   match_count, best_alt_count, best_alt_base
//  config    wr_en                  wr_index, wr_data
//
//  one input transaction per cycle, set by the single counter update stage
//  a kept site passes front, queue, snapshot, best-alt and output registers
//  synchronous reset clears counters, thresholds and all valid flags
//  output stalls back up through the queue to in_ready
// ----------------------------------------------------------------------------
module pileup_allele_count_filter #(
  parameter int COUNT_WIDTH = pacf_pkg::COUNT_WIDTH_DEF,
  parameter int FIFO_DEPTH  = pacf_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [pacf_pkg::CFG_IDX_WIDTH-1:0]   wr_index,
  input  wire logic [pacf_pkg::CFG_WIDTH-1:0]       wr_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [pacf_pkg::CHAR_WIDTH-1:0]      read_char,
  input  wire logic                                 char_present,
  input  wire logic                                 site_end,
  input  wire logic [pacf_pkg::POS_WIDTH-1:0]       site_position,
  input  wire logic [pacf_pkg::CHAR_WIDTH-1:0]      reference_base,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [pacf_pkg::POS_WIDTH-1:0]            kept_position,
  output logic [pacf_pkg::CHAR_WIDTH-1:0]           kept_reference,
  output logic [pacf_pkg::FIELD_WIDTH-1:0]          match_count,
  output logic [pacf_pkg::FIELD_WIDTH-1:0]          best_alt_count,
  output logic [pacf_pkg::BASE_WIDTH-1:0]           best_alt_base
);

  pacf_pkg::thresh_t thresh;
  logic              push, full, pop, pop_valid;
  pacf_pkg::item_t   push_item, pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= '0;
    end else if (wr_en) begin
      case (wr_index)
        pacf_pkg::REG_REF_THRESHOLD:   thresh.ref_min   <= wr_data;
        pacf_pkg::REG_ALT_THRESHOLD:   thresh.alt_min   <= wr_data;
        pacf_pkg::REG_TOTAL_THRESHOLD: thresh.total_min <= wr_data;
        default:                       ;
      endcase
    end
  end

  pacf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .read_char      (read_char),
    .char_present   (char_present),
    .site_end       (site_end),
    .site_position  (site_position),
    .reference_base (reference_base),
    .push           (push),
    .push_item      (push_item),
    .full           (full)
  );

  pacf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  pacf_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .thresh         (thresh),
    .item_valid     (pop_valid),
    .item           (pop_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kept_position  (kept_position),
    .kept_reference (kept_reference),
    .match_count    (match_count),
    .best_alt_count (best_alt_count),
    .best_alt_base  (best_alt_base)
  );

endmodule
`default_nettype wire

// ----- test/pileup_allele_count_filter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pileup_allele_count_filter_tb
// Self-checking bench for the pileup allele count filter. A directed table
// covers empty fields, every character class, ties and extremes. Random
// pileup sites then run under several threshold settings and idle patterns.
// Every kept site is scored against a behavioral tally of the site or a typed
// expectation, and compared field by field in arrival order.
// ----------------------------------------------------------------------------
module pileup_allele_count_filter_tb;
  import pacf_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [POS_WIDTH-1:0]   pos;
    logic [CHAR_WIDTH-1:0]  refb;
    logic [FIELD_WIDTH-1:0] match;
    logic [FIELD_WIDTH-1:0] alt;
    base_t                  base;
  } kept_site_t;

  typedef enum int {ROW_PREDICT, ROW_KEEP, ROW_DROP} row_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [CHAR_WIDTH-1:0] ch;
    logic                  present;
    logic                  last;
    logic [POS_WIDTH-1:0]  pos;
    logic [CHAR_WIDTH-1:0] refb;
    row_kind_t             kind;
    kept_site_t            typed;
  } stim_row_t;

  logic                     clk            = 1'b0;
  logic                     rst            = 1'b1;
  logic                     wr_en          = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] wr_index       = '0;
  logic [CFG_WIDTH-1:0]     wr_data        = '0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic [CHAR_WIDTH-1:0]    read_char      = '0;
  logic                     char_present   = 1'b0;
  logic                     site_end       = 1'b0;
  logic [POS_WIDTH-1:0]     site_position  = '0;
  logic [CHAR_WIDTH-1:0]    reference_base = '0;
  logic                     out_valid;
  logic                     out_ready      = 1'b0;
  logic [POS_WIDTH-1:0]     kept_position;
  logic [CHAR_WIDTH-1:0]    kept_reference;
  logic [FIELD_WIDTH-1:0]   match_count;
  logic [FIELD_WIDTH-1:0]   best_alt_count;
  logic [BASE_WIDTH-1:0]    best_alt_base;

  logic [15:0] thr_ref   = '0;
  logic [15:0] thr_alt   = '0;
  logic [15:0] thr_total = '0;
  logic [15:0] tot_chars = '0;
  logic [15:0] ref_hits  = '0;
  logic [15:0] base_hits [4] = '{16'd0, 16'd0, 16'd0, 16'd0};

  kept_site_t kept_sites_q [$];
  stim_row_t  directed_rows [$];
  int         fail_count     = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;

  pileup_allele_count_filter i_dut (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .read_char      (read_char),
    .char_present   (char_present),
    .site_end       (site_end),
    .site_position  (site_position),
    .reference_base (reference_base),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kept_position  (kept_position),
    .kept_reference (kept_reference),
    .match_count    (match_count),
    .best_alt_count (best_alt_count),
    .best_alt_base  (best_alt_base)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // one character of a site; at site end decides whether the site is kept
  function automatic bit score_site_item(input logic [CHAR_WIDTH-1:0] ch, input logic present,
                                         input logic last, input logic [POS_WIDTH-1:0] pos,
                                         input logic [CHAR_WIDTH-1:0] refb,
                                         output kept_site_t site);
    logic [15:0] best_cnt;
    base_t       best;
    logic [16:0] pair_sum;
    bit          keep;
    site = '0;
    if (present) begin
      tot_chars = bump(tot_chars);
      case (ch)
        CHAR_DOT, CHAR_COMMA: ref_hits = bump(ref_hits);
        CHAR_UA, CHAR_LA:     base_hits[BASE_A] = bump(base_hits[BASE_A]);
        CHAR_UC, CHAR_LC:     base_hits[BASE_C] = bump(base_hits[BASE_C]);
        CHAR_UG, CHAR_LG:     base_hits[BASE_G] = bump(base_hits[BASE_G]);
        CHAR_UT, CHAR_LT:     base_hits[BASE_T] = bump(base_hits[BASE_T]);
        default: ;
      endcase
    end
    if (!last) return 1'b0;
    best     = BASE_A;
    best_cnt = base_hits[BASE_A];
    for (int i = 1; i < 4; i++) begin
      if (base_hits[i] > best_cnt) begin
        best_cnt = base_hits[i];
        best     = base_t'(i);
      end
    end
    pair_sum = {1'b0, ref_hits} + {1'b0, best_cnt};
    keep = (tot_chars >= thr_total) && (ref_hits >= thr_ref) && (best_cnt >= thr_alt)
        && (pair_sum >= {1'b0, thr_total});
    site = '{pos, refb, ref_hits, best_cnt, best};
    tot_chars = '0;
    ref_hits  = '0;
    for (int i = 0; i < 4; i++) base_hits[i] = '0;
    return keep;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] base_char(input base_t b, input bit lower);
    case (b)
      BASE_A:  return lower ? CHAR_LA : CHAR_UA;
      BASE_C:  return lower ? CHAR_LC : CHAR_UC;
      BASE_G:  return lower ? CHAR_LG : CHAR_UG;
      default: return lower ? CHAR_LT : CHAR_UT;
    endcase
  endfunction

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 52; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 52; end
      default:       begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  // drive one transaction and return at the edge that accepts it
  task automatic apply_item(input logic [CHAR_WIDTH-1:0] ch, input logic present,
                            input logic last, input logic [POS_WIDTH-1:0] pos,
                            input logic [CHAR_WIDTH-1:0] refb, input row_kind_t kind,
                            input kept_site_t typed);
    kept_site_t site;
    bit         keep;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    read_char      <= ch;
    char_present   <= present;
    site_end       <= last;
    site_position  <= pos;
    reference_base <= refb;
    do @(posedge clk); while (!in_ready);
    keep = score_site_item(ch, present, last, pos, refb, site);
    case (kind)
      ROW_KEEP:    kept_sites_q.push_back(typed);
      ROW_PREDICT: if (keep) kept_sites_q.push_back(site);
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (kept_sites_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    case (idx)
      REG_REF_THRESHOLD:   thr_ref   = val;
      REG_ALT_THRESHOLD:   thr_alt   = val;
      REG_TOTAL_THRESHOLD: thr_total = val;
      default: ;
    endcase
  endtask

  task automatic write_thresholds(input logic [15:0] r, input logic [15:0] a,
                                  input logic [15:0] t);
    write_reg(REG_REF_THRESHOLD, r);
    write_reg(REG_ALT_THRESHOLD, a);
    write_reg(REG_TOTAL_THRESHOLD, t);
    write_reg(REG_UNUSED, CFG_WIDTH'($urandom_range(0, 16'hFFFF)));
    wr_en <= 1'b0;
  endtask

  task automatic add_row(input logic [CHAR_WIDTH-1:0] ch, input logic present, input logic last,
                         input logic [POS_WIDTH-1:0] pos, input logic [CHAR_WIDTH-1:0] refb,
                         input row_kind_t kind, input kept_site_t typed);
    stim_row_t row;
    row = '{ch, present, last, pos, refb, kind, typed};
    directed_rows.push_back(row);
  endtask

  task automatic run_random_sites(input int n_items);
    int                    taken;
    int                    len;
    int                    r;
    base_t                 favored;
    logic [CHAR_WIDTH-1:0] ch;
    logic                  present;
    taken = 0;
    while (taken < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      favored = base_t'($urandom_range(0, 3));
      for (int k = 0; k < len; k++) begin
        r       = $urandom_range(0, 99);
        present = 1'b1;
        if (r < 30) ch = $urandom_range(0, 1) ? CHAR_DOT : CHAR_COMMA;
        else if (r < 60) ch = base_char(favored, 1'($urandom_range(0, 1)));
        else if (r < 80) ch = base_char(base_t'($urandom_range(0, 3)),
                                        1'($urandom_range(0, 1)));
        else if (r < 92) ch = CHAR_WIDTH'($urandom_range(0, 255));
        else begin
          ch      = CHAR_WIDTH'($urandom_range(0, 255));
          present = 1'b0;
        end
        apply_item(ch, present, k == len - 1, POS_WIDTH'($urandom_range(0, 32'h7FFF_FFFF)),
                   CHAR_WIDTH'($urandom_range(0, 255)), ROW_PREDICT, '0);
        taken++;
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    kept_site_t want;
    if (!rst && out_valid && out_ready) begin
      if (kept_sites_q.size() == 0) begin
        report_mismatch("unexpected transaction position", kept_position, 0);
      end else begin
        want = kept_sites_q.pop_front();
        if (kept_position !== want.pos)
          report_mismatch("kept_position", kept_position, want.pos);
        if (kept_reference !== want.refb)
          report_mismatch("kept_reference", kept_reference, want.refb);
        if (match_count !== want.match)
          report_mismatch("match_count", match_count, want.match);
        if (best_alt_count !== want.alt)
          report_mismatch("best_alt_count", best_alt_count, want.alt);
        if (best_alt_base !== want.base)
          report_mismatch("best_alt_base", best_alt_base, want.base);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_idle(IDLE_NONE);

    // empty field right after reset, all alternates zero
    add_row(8'h00, 1'b0, 1'b1, 31'd0, CHAR_UA, ROW_KEEP, '{31'd0, CHAR_UA, 16'd0, 16'd0, BASE_A});
    add_row(CHAR_DOT,   1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(CHAR_COMMA, 1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(CHAR_LA,    1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(CHAR_UA,    1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(CHAR_LC,    1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(8'h58,      1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(CHAR_UT,    1'b1, 1'b1, 31'h7FFF_FFFF, 8'hFF, ROW_PREDICT, '0);
    add_row(CHAR_LG,    1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(CHAR_UG,    1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    // absent character is ignored
    add_row(CHAR_DOT,   1'b0, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(CHAR_LT,    1'b1, 1'b1, 31'h2AAA_AAAA, CHAR_UC, ROW_PREDICT, '0);
    add_row(8'h00,      1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(8'hFF,      1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(CHAR_UC,    1'b1, 1'b1, 31'h5555_5555, CHAR_UG, ROW_PREDICT, '0);
    // tie between c and g
    add_row(CHAR_LG,    1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(CHAR_LC,    1'b1, 1'b1, 31'd1, CHAR_LT, ROW_PREDICT, '0);
    add_row(CHAR_UT,    1'b1, 1'b0, 31'd0, 8'h00, ROW_PREDICT, '0);
    add_row(CHAR_UG,    1'b0, 1'b1, 31'd77, CHAR_LA, ROW_PREDICT, '0);
    add_row(CHAR_COMMA, 1'b1, 1'b1, 31'd12345, CHAR_DOT, ROW_PREDICT, '0);
    foreach (directed_rows[i]) begin
      apply_item(directed_rows[i].ch, directed_rows[i].present, directed_rows[i].last,
                 directed_rows[i].pos, directed_rows[i].refb, directed_rows[i].kind,
                 directed_rows[i].typed);
    end
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_thresholds(16'd0, 16'd0, 16'd0);
        1: write_thresholds(16'd2, 16'd1, 16'd6);
        2: write_thresholds(16'hFFFF, 16'd0, 16'd0);
        3: write_thresholds(16'd0, 16'hFFFF, 16'd0);
        4: write_thresholds(16'd0, 16'd0, 16'hFFFF);
        5: write_thresholds(16'd3, 16'd2, 16'd4);
        6: write_thresholds(16'd1, 16'd1, 16'd10);
        default: write_thresholds(16'd0, 16'd3, 16'd8);
      endcase
      set_idle(idle_mode_t'(p % 4));
      run_random_sites(64);
      settle();
    end

    if (fail_count == 0 && kept_sites_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pacf_pkg.sv
hdl/pacf_front.sv
hdl/pacf_fifo.sv
hdl/pacf_back.sv
hdl/pileup_allele_count_filter.sv
test/pileup_allele_count_filter_tb.sv
